### rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define SFA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/core/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

	localparam int FE_W = 256;
	localparam int DIG_W = 32;

	typedef logic [FE_W-1:0] fe_t;

	localparam fe_t PRIME = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2F};
	localparam fe_t EXP_INV = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2D};
	localparam fe_t EXP_ROOT = {64'h3FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFBFFFFF0C};
	// 2^256 = 2^32 + 977 mod p
	localparam logic [DIG_W-1:0] FOLD_LO = 32'd977;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_NEG  = 3'd2,
		OP_MUL  = 3'd3,
		OP_SQR  = 3'd4,
		OP_INV  = 3'd5,
		OP_SQRT = 3'd6
	} op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] a_limb0;
		logic [63:0] a_limb1;
		logic [63:0] a_limb2;
		logic [63:0] a_limb3;
		logic [63:0] b_limb0;
		logic [63:0] b_limb1;
		logic [63:0] b_limb2;
		logic [63:0] b_limb3;
	} sfa_in_t;

	typedef struct packed {
		logic [63:0] res_limb0;
		logic [63:0] res_limb1;
		logic [63:0] res_limb2;
		logic [63:0] res_limb3;
		logic        valid_root;
	} sfa_out_t;

	typedef struct packed {
		logic start;
		fe_t  x;
		fe_t  y;
	} sfa_mul_req_t;

	typedef struct packed {
		logic done;
		fe_t  r;
	} sfa_mul_rsp_t;

endpackage
`default_nettype wire

### rtl/core/sfa_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module sfa_mul (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sfa_pkg::sfa_mul_req_t req,
	output sfa_pkg::sfa_mul_rsp_t      rsp
);
	import sfa_pkg::*;

	typedef enum logic [5:0] {
		M_IDLE  = 6'b000001,
		M_ROW   = 6'b000010,
		M_SHIFT = 6'b000100,
		M_CHK   = 6'b001000,
		M_PASS  = 6'b010000,
		M_CSUB  = 6'b100000
	} mstate_t;

	mstate_t state_q;
	fe_t a_q, b_q, w_q, lo_q, r_q;
	logic [DIG_W-1:0] c_q, prev_q;
	logic [2:0] i_q, j_q;
	logic [3:0] k_q;
	logic done_q;

	logic [DIG_W-1:0] mx, my;
	logic [63:0] prod, s_row, s_pass;
	logic [FE_W:0] d;

	// the one shared 32x32 multiplier
	assign mx = (state_q == M_ROW) ? a_q[DIG_W-1:0] : w_q[DIG_W-1:0];
	assign my = (state_q == M_ROW) ? b_q[DIG_W-1:0] : FOLD_LO;
	assign prod = {32'd0, mx} * {32'd0, my};

	assign s_row = {32'd0, w_q[DIG_W-1:0]} + prod + {32'd0, c_q};
	assign s_pass = (k_q == 4'd8) ? ({32'd0, prev_q} + {32'd0, c_q})
		: ({32'd0, lo_q[DIG_W-1:0]} + prod + {32'd0, prev_q} + {32'd0, c_q});
	assign d = {1'b0, lo_q} - {1'b0, PRIME};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_ROW;
						i_q <= '0;
						j_q <= '0;
					end
				end
				M_ROW: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd7) state_q <= M_SHIFT;
				end
				M_SHIFT: begin
					i_q <= i_q + 3'd1;
					if (i_q == 3'd7) state_q <= M_CHK;
					else state_q <= M_ROW;
				end
				M_CHK: begin
					k_q <= '0;
					if (w_q == '0) state_q <= M_CSUB;
					else state_q <= M_PASS;
				end
				M_PASS: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'd8) state_q <= M_CHK;
				end
				M_CSUB: begin
					done_q <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			M_IDLE: begin
				a_q <= req.x;
				b_q <= req.y;
				w_q <= '0;
				lo_q <= '0;
				c_q <= '0;
			end
			M_ROW: begin
				w_q <= {s_row[DIG_W-1:0], w_q[FE_W-1:DIG_W]};
				b_q <= {b_q[DIG_W-1:0], b_q[FE_W-1:DIG_W]};
				c_q <= s_row[63:32];
			end
			M_SHIFT: begin
				lo_q <= {w_q[DIG_W-1:0], lo_q[FE_W-1:DIG_W]};
				w_q <= {c_q, w_q[FE_W-1:DIG_W]};
				a_q <= {32'd0, a_q[FE_W-1:DIG_W]};
				c_q <= '0;
			end
			M_CHK: begin
				c_q <= '0;
				prev_q <= '0;
			end
			M_PASS: begin
				c_q <= s_pass[63:32];
				if (k_q == 4'd8) begin
					w_q <= {192'd0, s_pass};
				end else begin
					lo_q <= {s_pass[DIG_W-1:0], lo_q[FE_W-1:DIG_W]};
					prev_q <= w_q[DIG_W-1:0];
					w_q <= {32'd0, w_q[FE_W-1:DIG_W]};
				end
			end
			M_CSUB: r_q <= d[FE_W] ? lo_q : d[FE_W-1:0];
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.r = r_q;
endmodule
`default_nettype wire

### rtl/core/secp256k1_field_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake            | payload
// req     | in  | req_valid, req_ready | sfa_in_t  (opcode, a, b limbs)
// rsp     | out | rsp_valid, rsp_ready | sfa_out_t (res limbs, valid_root)
// One item at a time; req_ready is high only while idle.
// add, sub, neg use the adder; mul and sqr run on the shared 32x32 multiplier
// (schoolbook digits plus fold passes).
// inv: 256 squarings plus one multiply per set exponent bit; sqrt adds
// one check squaring. A stalled result holds in the output register.
// Reset clears the sequencers only.
module secp256k1_field_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire sfa_pkg::sfa_in_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output sfa_pkg::sfa_out_t     rsp
);
	import sfa_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_REDA = 14'b00000000000010,
		S_REDB = 14'b00000000000100,
		S_OP   = 14'b00000000001000,
		S_FIX  = 14'b00000000010000,
		S_MUL  = 14'b00000000100000,
		S_MULW = 14'b00000001000000,
		S_PBIT = 14'b00000010000000,
		S_PAW  = 14'b00000100000000,
		S_PSQ  = 14'b00001000000000,
		S_PSW  = 14'b00010000000000,
		S_CHK  = 14'b00100000000000,
		S_CHKW = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	fe_t a_q, b_q, r_q, acc_q, base_q;
	logic carry_q, flag_q;
	logic [7:0] cnt_q;

	fe_t ux, uy;
	logic usub;
	logic [FE_W:0] usum;
	fe_t exp_sel;
	sfa_mul_req_t mreq;
	sfa_mul_rsp_t mrsp;

	sfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign exp_sel = (op_q == OP_SQRT) ? EXP_ROOT : EXP_INV;

	always_comb begin
		ux = a_q;
		uy = PRIME;
		usub = 1'b1;
		unique case (state_q)
			S_REDB: ux = b_q;
			S_OP: begin
				uy = b_q;
				usub = (op_q != OP_ADD);
				if (op_q == OP_NEG) begin
					ux = '0;
					uy = a_q;
				end
			end
			S_FIX: begin
				ux = r_q;
				usub = (op_q == OP_ADD);
			end
			default: ;
		endcase
	end

	assign usum = {1'b0, ux} + ({1'b0, uy} ^ {(FE_W+1){usub}}) + {{FE_W{1'b0}}, usub};

	always_comb begin
		mreq.start = 1'b0;
		mreq.x = acc_q;
		mreq.y = base_q;
		unique case (state_q)
			S_MUL: begin
				mreq.start = 1'b1;
				mreq.x = a_q;
				mreq.y = (op_q == OP_SQR) ? a_q : b_q;
			end
			S_PBIT: mreq.start = exp_sel[cnt_q];
			S_PSQ: begin
				mreq.start = 1'b1;
				mreq.x = base_q;
			end
			S_CHK: begin
				mreq.start = 1'b1;
				mreq.y = acc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (req_valid) state_q <= S_REDA;
				S_REDA: state_q <= S_REDB;
				S_REDB: state_q <= S_OP;
				S_OP: begin
					unique case (op_q)
						OP_ADD, OP_SUB, OP_NEG: state_q <= S_FIX;
						OP_MUL, OP_SQR: state_q <= S_MUL;
						OP_INV, OP_SQRT: state_q <= S_PBIT;
						default: state_q <= S_OUT;
					endcase
				end
				S_FIX: state_q <= S_OUT;
				S_MUL: state_q <= S_MULW;
				S_MULW: if (mrsp.done) state_q <= S_OUT;
				S_PBIT: state_q <= exp_sel[cnt_q] ? S_PAW : S_PSQ;
				S_PAW: if (mrsp.done) state_q <= S_PSQ;
				S_PSQ: state_q <= S_PSW;
				S_PSW: begin
					if (mrsp.done) begin
						if (cnt_q != 8'd255) state_q <= S_PBIT;
						else if (op_q == OP_SQRT) state_q <= S_CHK;
						else state_q <= S_OUT;
					end
				end
				S_CHK: state_q <= S_CHKW;
				S_CHKW: if (mrsp.done) state_q <= S_OUT;
				S_OUT: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= req.opcode;
				a_q <= {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
				b_q <= {req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
				flag_q <= 1'b1;
				r_q <= '0;
			end
			S_REDA: if (!usum[FE_W]) a_q <= usum[FE_W-1:0];
			S_REDB: if (!usum[FE_W]) b_q <= usum[FE_W-1:0];
			S_OP: begin
				// unnamed opcode leaves the result at zero
				if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_NEG)
					r_q <= usum[FE_W-1:0];
				carry_q <= usum[FE_W];
				acc_q <= {{(FE_W-1){1'b0}}, 1'b1};
				base_q <= a_q;
				cnt_q <= '0;
			end
			S_FIX: begin
				if (op_q == OP_ADD) begin
					if (carry_q || !usum[FE_W]) r_q <= usum[FE_W-1:0];
				end else if (carry_q) begin
					r_q <= usum[FE_W-1:0];
				end
			end
			S_MULW: if (mrsp.done) r_q <= mrsp.r;
			S_PAW: if (mrsp.done) acc_q <= mrsp.r;
			S_PSW: begin
				if (mrsp.done) begin
					base_q <= mrsp.r;
					cnt_q <= cnt_q + 8'd1;
					r_q <= acc_q;
				end
			end
			S_CHKW: begin
				if (mrsp.done && mrsp.r != a_q) begin
					r_q <= '0;
					flag_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp.res_limb0 = r_q[63:0];
	assign rsp.res_limb1 = r_q[127:64];
	assign rsp.res_limb2 = r_q[191:128];
	assign rsp.res_limb3 = r_q[255:192];
	assign rsp.valid_root = flag_q;
endmodule
`default_nettype wire

### rtl/core/sfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sfa_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire sfa_pkg::sfa_in_t  req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire sfa_pkg::sfa_out_t rsp
);
	import sfa_pkg::*;

	logic zero_res;

	assign zero_res = (rsp.res_limb0 == '0) && (rsp.res_limb1 == '0)
		&& (rsp.res_limb2 == '0) && (rsp.res_limb3 == '0);

	`SFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	`SFA_ASSERT_SAME(a_one_in_flight, rsp_valid, !req_ready)
	`SFA_ASSERT_SAME(a_bad_root_zero, rsp_valid && !rsp.valid_root, zero_res)
	`SFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`SFA_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
endmodule

bind secp256k1_field_alu sfa_checker u_sfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

### tb/sv/secp256k1_field_alu_tb.sv
`timescale 1ns / 1ps
module secp256k1_field_alu_tb;
	import sfa_pkg::*;

	localparam logic [2:0] OP_NOP = 3'd7;
	localparam int N_RANDOM = 380;
	localparam int MAX_POW_RANDOM = 6;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	sfa_in_t req;
	logic rsp_valid;
	logic rsp_ready;
	sfa_out_t rsp;

	sfa_in_t pending_q[$];
	sfa_out_t expected_q[$];
	int n_errors;
	int send_gap;
	int recv_stall;

	secp256k1_field_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic fe_t mod_p(logic [511:0] v);
		logic [511:0] m;
		m = v % {256'b0, PRIME};
		return m[255:0];
	endfunction

	function automatic fe_t mul_p(fe_t x, fe_t y);
		return mod_p({256'b0, x} * {256'b0, y});
	endfunction

	function automatic fe_t pow_p(fe_t x, fe_t e);
		fe_t acc;
		fe_t base;
		acc = 256'd1;
		base = x;
		for (int i = 0; i < 256; i++) begin
			if (e[i])
				acc = mul_p(acc, base);
			base = mul_p(base, base);
		end
		return acc;
	endfunction

	function automatic sfa_out_t field_result(sfa_in_t it);
		fe_t a;
		fe_t b;
		fe_t r;
		fe_t root;
		logic flag;
		sfa_out_t o;
		a = {it.a_limb3, it.a_limb2, it.a_limb1, it.a_limb0};
		b = {it.b_limb3, it.b_limb2, it.b_limb1, it.b_limb0};
		if (a >= PRIME) a = a - PRIME;
		if (b >= PRIME) b = b - PRIME;
		r = '0;
		flag = 1'b1;
		case (it.opcode)
			OP_ADD: r = mod_p({256'b0, a} + {256'b0, b});
			OP_SUB: r = mod_p({256'b0, a} + {256'b0, PRIME} - {256'b0, b});
			OP_NEG: r = mod_p({256'b0, PRIME} - {256'b0, a});
			OP_MUL: r = mul_p(a, b);
			OP_SQR: r = mul_p(a, a);
			OP_INV: r = pow_p(a, EXP_INV);
			OP_SQRT: begin
				root = pow_p(a, EXP_ROOT);
				if (mul_p(root, root) == a) begin
					r = root;
				end else begin
					flag = 1'b0;
				end
			end
			default: r = '0;
		endcase
		o.res_limb0 = r[63:0];
		o.res_limb1 = r[127:64];
		o.res_limb2 = r[191:128];
		o.res_limb3 = r[255:192];
		o.valid_root = flag;
		return o;
	endfunction

	function automatic fe_t rand_fe();
		fe_t v;
		for (int i = 0; i < 8; i++)
			v[i*32 +: 32] = $urandom;
		return v;
	endfunction

	function automatic fe_t pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 256'd1;
			2: return PRIME - 256'd1;
			3: return PRIME + 256'($urandom_range(0, 976));
			4: return '1;
			5: return 256'($urandom);
			default: return rand_fe();
		endcase
	endfunction

	function automatic sfa_in_t make_item(logic [2:0] op, fe_t a, fe_t b);
		sfa_in_t it;
		it.opcode = op;
		{it.a_limb3, it.a_limb2, it.a_limb1, it.a_limb0} = a;
		{it.b_limb3, it.b_limb2, it.b_limb1, it.b_limb0} = b;
		return it;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready)
				expected_q.push_back(field_result(req));
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
					send_gap <= $urandom_range(0, 9);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		sfa_out_t want;
		int stall_next;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			stall_next = recv_stall > 0 ? recv_stall - 1 : 0;
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected");
					n_errors++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.res_limb0 !== want.res_limb0) begin
						$error("res_limb0 exp %h got %h", want.res_limb0, rsp.res_limb0);
						n_errors++;
					end
					if (rsp.res_limb1 !== want.res_limb1) begin
						$error("res_limb1 exp %h got %h", want.res_limb1, rsp.res_limb1);
						n_errors++;
					end
					if (rsp.res_limb2 !== want.res_limb2) begin
						$error("res_limb2 exp %h got %h", want.res_limb2, rsp.res_limb2);
						n_errors++;
					end
					if (rsp.res_limb3 !== want.res_limb3) begin
						$error("res_limb3 exp %h got %h", want.res_limb3, rsp.res_limb3);
						n_errors++;
					end
					if (rsp.valid_root !== want.valid_root) begin
						$error("valid_root exp %b got %b", want.valid_root, rsp.valid_root);
						n_errors++;
					end
				end
				stall_next = $urandom_range(0, 9);
			end
			recv_stall <= stall_next;
			rsp_ready <= (stall_next == 0);
		end
	end

	initial begin
		fe_t x;
		logic [2:0] op;
		int n_pow;
		n_errors = 0;
		n_pow = 0;
		arst_n = 1'b0;

		pending_q.push_back(make_item(OP_ADD, PRIME - 256'd1, 256'd1));
		pending_q.push_back(make_item(OP_ADD, '1, '1));
		pending_q.push_back(make_item(OP_ADD, PRIME, '0));
		pending_q.push_back(make_item(OP_SUB, '0, 256'd1));
		pending_q.push_back(make_item(OP_SUB, PRIME + 256'd5, '1));
		pending_q.push_back(make_item(OP_NEG, '0, '1));
		pending_q.push_back(make_item(OP_NEG, PRIME, rand_fe()));
		pending_q.push_back(make_item(OP_NEG, 256'd1, '0));
		pending_q.push_back(make_item(OP_MUL, '1, '1));
		pending_q.push_back(make_item(OP_MUL, PRIME - 256'd1, PRIME - 256'd1));
		pending_q.push_back(make_item(OP_MUL, '0, rand_fe()));
		pending_q.push_back(make_item(OP_SQR, PRIME - 256'd1, rand_fe()));
		pending_q.push_back(make_item(OP_SQR, '1, '0));
		pending_q.push_back(make_item(OP_NOP, '1, '1));
		pending_q.push_back(make_item(OP_NOP, rand_fe(), rand_fe()));
		pending_q.push_back(make_item(OP_INV, '0, '1));
		pending_q.push_back(make_item(OP_INV, PRIME, '0));
		pending_q.push_back(make_item(OP_INV, 256'd2, '0));
		pending_q.push_back(make_item(OP_SQRT, '0, '1));
		pending_q.push_back(make_item(OP_SQRT, PRIME + 256'd4, '0));
		x = rand_fe();
		pending_q.push_back(make_item(OP_SQRT, mul_p(x, x), '0));
		pending_q.push_back(make_item(OP_SQRT, PRIME - mul_p(x, x), '0));

		for (int i = 0; i < N_RANDOM; i++) begin
			op = 3'($urandom_range(0, 7));
			if ((op == OP_INV || op == OP_SQRT) && n_pow >= MAX_POW_RANDOM)
				op = 3'($urandom_range(0, 4));
			if ((op == OP_INV || op == OP_SQRT) && $urandom_range(0, 19) != 0)
				op = 3'($urandom_range(0, 4));
			if (op == OP_INV || op == OP_SQRT)
				n_pow++;
			x = pick_operand();
			if (op == OP_SQRT && $urandom_range(0, 1))
				x = mul_p(x, x);
			pending_q.push_back(make_item(op, x, pick_operand()));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0);
		@(posedge clk);
		while (req_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
